// ===== rtl/core/mkdl_pkg.sv =====
// Shared types and constants for the multi-key debounce and long-press detector.
package mkdl_pkg;

  // Width of the key level and event fields on the channels.
  localparam int KEY_W        = 5;
  localparam int NUM_KEYS_DEF = 5;
  localparam int TICK_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 16'd100;
  localparam logic [KEY_W-1:0]  SHORT_MASK_RST  = 5'h1F;
  localparam logic [KEY_W-1:0]  LONG_MASK_RST   = 5'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_TICKS = 2'd0,
    CFG_SHORT_MASK = 2'd1,
    CFG_LONG_MASK  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_COUNTING = 2'd2,
    PH_WAIT     = 2'd3
  } key_phase_t;

  // Events raised by one lane on the current tick.
  typedef struct packed {
    logic short_evt;
    logic long_evt;
  } lane_evt_t;

endpackage

// ===== rtl/core/mkdl_ifs.sv =====
// Valid/ready channel interfaces for the key level input and the event output.
interface mkdl_in_if
  import mkdl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

interface mkdl_out_if
  import mkdl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] short_events;
  logic [KEY_W-1:0] long_events;

  modport source (output valid, output short_events, output long_events, input ready);
  modport sink   (input valid, input short_events, input long_events, output ready);
endinterface

// ===== rtl/core/mkdl_lane.sv =====
// One key lane: the four-phase press machine and its hold counter.
module mkdl_lane
  import mkdl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              key_low,
  input  logic [TICK_W-1:0] long_press_ticks,
  output lane_evt_t         evt
);

  key_phase_t        phase_r, phase_nxt;
  logic [TICK_W-1:0] hold_r, hold_nxt;
  logic [TICK_W-1:0] hold_inc;

  assign hold_inc = hold_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hold_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    hold_nxt      = hold_r;
    evt.short_evt = 1'b0;
    evt.long_evt  = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (key_low) phase_nxt = PH_DEBOUNCE;
      end
      PH_DEBOUNCE: begin
        if (key_low) begin
          phase_nxt = PH_COUNTING;
          hold_nxt  = '0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_COUNTING: begin
        if (key_low) begin
          hold_nxt = hold_inc;
          // The counter wraps, so a zero threshold fires after a full wrap.
          if (hold_inc == long_press_ticks) begin
            evt.long_evt = 1'b1;
            phase_nxt    = PH_WAIT;
          end
        end else begin
          evt.short_evt = 1'b1;
          phase_nxt     = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (!key_low) phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_long_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    step && evt.long_evt |=> phase_r == PH_WAIT)
    else $error("long press did not move the key to wait-for-release");

  a_short_from_counting: assert property (@(posedge clk) disable iff (!rst_n)
    evt.short_evt |-> phase_r == PH_COUNTING && !key_low)
    else $error("short press raised outside the counting phase");

  a_hold_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_DEBOUNCE && key_low |=> hold_r == '0 && phase_r == PH_COUNTING)
    else $error("hold counter not cleared on entry to counting");
`endif

endmodule

// ===== rtl/core/mkdl_merge.sv =====
// Merging stage: gathers lane events, applies enable masks and holds the result.
module mkdl_merge
  import mkdl_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  output logic             in_ready,
  input  lane_evt_t        lane_evt [NUM_KEYS],
  input  logic [KEY_W-1:0] short_enable_mask,
  input  logic [KEY_W-1:0] long_enable_mask,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KEY_W-1:0] short_events,
  output logic [KEY_W-1:0] long_events
);

  logic             out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0] short_r, long_r;
  logic [KEY_W-1:0] shorts, longs;

  // Lanes past the field width are dropped; missing lanes report nothing.
  for (genvar i = 0; i < KEY_W; i++) begin : g_gather
    if (i < NUM_KEYS) begin : g_lane
      assign shorts[i] = lane_evt[i].short_evt;
      assign longs[i]  = lane_evt[i].long_evt;
    end else begin : g_none
      assign shorts[i] = 1'b0;
      assign longs[i]  = 1'b0;
    end
  end

  assign in_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      short_r <= shorts & short_enable_mask;
      long_r  <= longs & long_enable_mask;
    end
  end

  assign out_valid    = out_valid_r;
  assign short_events = short_r;
  assign long_events  = long_r;

`ifndef SYNTHESIS
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !in_fire |=> !out_valid_r)
    else $error("result held after it was taken");

  a_no_double_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (short_r & long_r) == '0)
    else $error("one key reported short and long press on the same tick");
`endif

endmodule

// ===== rtl/core/multi_key_debounce_long_press.sv =====
// Top level of the multi-key debounce and short/long press detector.
//
// Usage: each transaction on in_chan is one scan tick carrying the raw
// active-low levels of the keys in key_levels. For every accepted tick exactly
// one transaction leaves on out_chan with short_events and long_events masks.
// Every key has its own lane (phase machine plus 16-bit hold counter); all
// lanes step together on the tick, and a merging stage masks the events and
// registers the result.
// out_chan.valid rises in the cycle after a tick is accepted. While the
// receiver keeps out_chan.ready high, a tick can be taken every cycle:
// in_chan.ready is high when the output register is empty or is being
// emptied in the same cycle, so the single output register sets the rate.
// A stalled result is held, with in_chan.ready low until the register frees.
// Reset (rst_n low at a clock edge) puts every key in idle with a zero counter,
// empties the output register and loads long_press_ticks = 100, all short
// presses enabled and all long presses disabled. Configuration is written
// through cfg_we/cfg_index/cfg_data while no tick is in flight; index 0 is the
// long-press threshold, 1 the short enable mask, 2 the long enable mask.
module multi_key_debounce_long_press
  import mkdl_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mkdl_in_if.sink               in_chan,
  mkdl_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TICK_W-1:0] long_press_ticks_r;
  logic [KEY_W-1:0]  short_enable_mask_r;
  logic [KEY_W-1:0]  long_enable_mask_r;
  logic              in_ready;
  logic              in_fire;
  lane_evt_t         lane_evt [NUM_KEYS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_ticks_r  <= LONG_TICKS_RST;
      short_enable_mask_r <= SHORT_MASK_RST;
      long_enable_mask_r  <= LONG_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LONG_TICKS: long_press_ticks_r  <= cfg_data[TICK_W-1:0];
        CFG_SHORT_MASK: short_enable_mask_r <= cfg_data[KEY_W-1:0];
        CFG_LONG_MASK:  long_enable_mask_r  <= cfg_data[KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_fire       = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic key_low;
    // Keys without an input bit read as pressed.
    if (k < KEY_W) begin : g_in
      assign key_low = !in_chan.key_levels[k];
    end else begin : g_tied
      assign key_low = 1'b1;
    end

    mkdl_lane u_lane (
      .clk              (clk),
      .rst_n            (rst_n),
      .step             (in_fire),
      .key_low          (key_low),
      .long_press_ticks (long_press_ticks_r),
      .evt              (lane_evt[k])
    );
  end

  mkdl_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_fire           (in_fire),
    .in_ready          (in_ready),
    .lane_evt          (lane_evt),
    .short_enable_mask (short_enable_mask_r),
    .long_enable_mask  (long_enable_mask_r),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .short_events      (out_chan.short_events),
    .long_events       (out_chan.long_events)
  );

endmodule
